// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that is also checked across reset
`define ASSERT_NXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/bed_pkg.sv =====
// types and constants of the backslash escape decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

    // payload of one input transfer
    typedef struct packed {
        logic [7:0] ch;
        logic       string_end;
    } t_in_item;

    // payload of one output transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    // decoded job passed from front to back
    typedef struct packed {
        logic        utf8;
        logic [15:0] value;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [2:0] NEED_HEXB = 3'd2;
    localparam logic [2:0] NEED_HEXU = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/bed_if.sv =====
// valid/ready channel interfaces for the decoder input and output
// depends on bed_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bed_in_if;
    import bed_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bed_out_if;
    import bed_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bed_front.sv =====
// front end: escape parser that turns input bytes into decode jobs
// depends on bed_pkg and bed_if
`timescale 1ns / 1ps
`default_nettype none

module bed_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bed_in_if.sink             i_in,
    input  bed_pkg::t_q_status i_q_stat,
    output logic               o_push,
    output bed_pkg::t_job      o_job
);
    import bed_pkg::*;

    typedef enum logic [3:0] {
        PH_TEXT = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_HEXB = 4'b0100,
        PH_HEXU = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_digits, n_digits;
    logic [15:0] r_code, n_code;
    logic        r_stop, n_stop;

    logic        accept;
    logic [7:0]  ch;
    logic        last;
    logic        is_hex;
    logic [3:0]  digit;
    logic [2:0]  digits_inc;
    logic [15:0] code_upd;
    logic        hex_done;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign ch         = i_in.data.ch;
    assign last       = i_in.data.string_end;

    always_comb begin
        is_hex = 1'b1;
        digit  = ch[3:0];
        if (ch >= 8'h30 && ch <= 8'h39) begin
            digit = ch[3:0];
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            digit = ch[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign digits_inc = r_digits + 3'd1;
    assign code_upd   = (!r_stop && is_hex) ? {r_code[11:0], digit} : r_code;
    assign hex_done   = last || (digits_inc >= ((r_phase == PH_HEXB) ? NEED_HEXB : NEED_HEXU));

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_code   = r_code;
        n_stop   = r_stop;
        o_push   = 1'b0;
        o_job    = '{utf8: 1'b0, value: {8'h00, ch}};
        if (accept) begin
            unique case (r_phase)
                PH_ESC: begin
                    n_phase  = PH_TEXT;
                    n_digits = '0;
                    n_code   = '0;
                    n_stop   = 1'b0;
                    o_push   = 1'b1;
                    unique case (ch)
                        CH_E: o_job.value = {8'h00, BYTE_ESC};
                        CH_N: o_job.value = {8'h00, BYTE_LF};
                        CH_R: o_job.value = {8'h00, BYTE_CR};
                        CH_T: o_job.value = {8'h00, BYTE_TAB};
                        CH_X: begin
                            o_job.value = '0;
                            o_push      = last;
                            n_phase     = PH_HEXB;
                        end
                        CH_U: begin
                            o_job = '{utf8: 1'b1, value: 16'h0000};
                            o_push  = last;
                            n_phase = PH_HEXU;
                        end
                        default: o_job.value = {8'h00, ch};
                    endcase
                end
                PH_HEXB, PH_HEXU: begin
                    n_code   = code_upd;
                    n_stop   = r_stop || !is_hex;
                    n_digits = digits_inc;
                    o_job    = '{utf8: (r_phase == PH_HEXU),
                                 value: (r_phase == PH_HEXU) ? code_upd
                                                             : {8'h00, code_upd[7:0]}};
                    if (hex_done) begin
                        o_push   = 1'b1;
                        n_phase  = PH_TEXT;
                        n_digits = '0;
                        n_code   = '0;
                        n_stop   = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_TEXT;
                    if (ch == CH_BSLASH) begin
                        if (!last) begin
                            n_phase = PH_ESC;
                        end
                    end else begin
                        o_push = 1'b1;
                    end
                end
            endcase
            if (last) begin
                n_phase  = PH_TEXT;
                n_digits = '0;
                n_code   = '0;
                n_stop   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TEXT;
            r_digits <= '0;
            r_code   <= '0;
            r_stop   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_code   <= n_code;
            r_stop   <= n_stop;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bed_queue.sv =====
// short job queue between the parser and the byte emitter
// depends on bed_pkg
`timescale 1ns / 1ps
`default_nettype none

module bed_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  bed_pkg::t_job       i_wr_job,
    input  wire logic           i_pop,
    output bed_pkg::t_job       o_rd_job,
    output bed_pkg::t_q_status  o_stat
);
    import bed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_rd_job     = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bed_back.sv =====
// back end: emits one output byte per cycle from queued jobs while o_out is ready, utf-8 encoding
// depends on bed_pkg and bed_if
`timescale 1ns / 1ps
`default_nettype none

module bed_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  bed_pkg::t_job      i_job,
    input  bed_pkg::t_q_status i_q_stat,
    output logic               o_pop,
    bed_out_if.source          o_out
);
    import bed_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic [1:0] r_idx, n_idx;

    logic       load;
    logic [1:0] last_idx;
    logic [15:0] cp;

    assign cp   = i_job.value;
    assign load = !i_q_stat.empty && (!r_valid || o_out.ready);

    // index of the final byte of this job
    always_comb begin
        if (!i_job.utf8 || cp < 16'h0080) begin
            last_idx = 2'd0;
        end else if (cp < 16'h0800) begin
            last_idx = 2'd1;
        end else begin
            last_idx = 2'd2;
        end
    end

    always_comb begin
        n_byte = cp[7:0];
        unique case (last_idx)
            2'd1: begin
                n_byte = (r_idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            2'd2: begin
                unique case (r_idx)
                    2'd0:    n_byte = {4'b1110, cp[15:12]};
                    2'd1:    n_byte = {2'b10, cp[11:6]};
                    default: n_byte = {2'b10, cp[5:0]};
                endcase
            end
            default: n_byte = cp[7:0];
        endcase
        n_last = (r_idx == last_idx);
        n_idx  = n_last ? 2'd0 : r_idx + 2'd1;
    end

    assign o_pop               = load && n_last;
    assign o_out.valid         = r_valid;
    assign o_out.data.out_byte = r_byte;
    assign o_out.data.run_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/backslash_escape_decoder.sv =====
// top level of the backslash escape decoder: parser, job queue and byte emitter
// depends on bed_pkg, bed_if, bed_front, bed_queue and bed_back
//
// usage
// - i_in carries one raw text byte per transfer (ch) and string_end, which marks
//   the final byte of a string; o_out carries decoded bytes, with run_last set on
//   the final byte of each job
// - the parser takes one byte per cycle while the queue is not full and pushes
//   at most one job per byte into a queue of QUEUE_DEPTH entries; the emitter
//   turns a job into one to three bytes (utf-8 for \u escapes) at one byte per
//   cycle while o_out is ready
// - path: a job is written into the queue, then into the output register
// - throughput: one input byte per cycle sustained while o_out is ready; the
//   emitter output rate of one byte per cycle sets it, and a \u escape with 2
//   output bytes spans at least 4 input bytes, with 3 output bytes at least 5,
//   so it keeps pace
// - receiver stall: the output register holds its byte; the queue absorbs up to
//   QUEUE_DEPTH jobs, after which i_in.ready drops
// - reset (synchronous, active low) returns the parser to plain text, empties
//   the queue and clears o_out.valid; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module backslash_escape_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bed_in_if.sink    i_in,
    bed_out_if.source o_out
);
    import bed_pkg::*;

    // jobs written by the parser
    logic      push;
    t_job      wr_job;
    // head job read by the emitter
    logic      pop;
    t_job      rd_job;
    t_q_status q_stat;

    // front: escape state machine, stalls only on a full queue
    bed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (wr_job)
    );

    // queue decouples parser from emitter stalls
    bed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_job (wr_job),
        .i_pop    (pop),
        .o_rd_job (rd_job),
        .o_stat   (q_stat)
    );

    // back: utf-8 encoder and output register
    bed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (rd_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bed_checker.sv =====
// port-level checker for the backslash escape decoder and its bind
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bed_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    logic       out_xfer;
    logic       out_stall;
    logic [8:0] out_word;
    logic       mid_xfer;
    logic       lead3_xfer;
    logic       cont_byte;

    assign out_xfer   = i_out_valid && i_out_ready;
    assign out_stall  = i_out_valid && !i_out_ready;
    assign out_word   = {i_out_byte, i_out_last};
    assign mid_xfer   = out_xfer && !i_out_last;
    assign lead3_xfer = mid_xfer && (i_out_byte[7:5] == 3'b111);
    assign cont_byte  = (i_out_byte[7:6] == 2'b10);

    // stalled output holds its byte
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))

    // nothing is offered right after reset
    `ASSERT_NXT_ANY(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)

    // a byte that is not last is a utf-8 lead or middle byte, followed at once by a continuation
    `ASSERT_NXT(a_utf8_cont, i_clk, i_rst_n, mid_xfer, i_out_valid && cont_byte)

    // a three-byte lead is followed by a middle byte that is not last
    `ASSERT_NXT(a_utf8_mid, i_clk, i_rst_n, lead3_xfer, i_out_valid && !i_out_last)

    // a non-last byte never stands alone as a plain ascii byte
    `ASSERT_IMP(a_not_last_high, i_clk, i_rst_n, i_out_valid && !i_out_last, i_out_byte[7])

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.data.out_byte),
    .i_out_last  (o_out.data.run_last)
);

`default_nettype wire
